// ----- sv/ddd_pkg.sv -----
// Shared types, constants and calendar functions of the date difference unit.
`default_nettype none

package ddd_pkg;

	// Field widths
	localparam int DAY_W   = 5;
	localparam int MONTH_W = 4;
	localparam int YEAR_W  = 14;
	localparam int COUNT_W = 22;

	// Accepted year range
	localparam logic [YEAR_W-1:0] MIN_YEAR = 14'd1601;
	localparam logic [YEAR_W-1:0] MAX_YEAR = 14'd9999;

	// Saturation value of the day count
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	localparam logic [MONTH_W-1:0] JANUARY  = 4'd1;
	localparam logic [MONTH_W-1:0] FEBRUARY = 4'd2;
	localparam logic [MONTH_W-1:0] DECEMBER = 4'd12;

	// floor(y / 100) = (y * 5243) >> 19, exact for any 14-bit year
	localparam int              RECIP_W     = 13;
	localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
	localparam int              RECIP_SHIFT = 19;
	localparam int              PROD_W      = YEAR_W + RECIP_W;
	localparam int              CENT_W      = 8;
	localparam logic [YEAR_W-1:0] YEARS_PER_CENTURY = 14'd100;
	localparam logic [6:0]      LAST_IN_CENTURY   = 7'd99;

	typedef enum logic [1:0] {
		ERR_NONE    = 2'd0,
		ERR_ORDER   = 2'd1,
		ERR_INVALID = 2'd2
	} err_t;

	// Year residues: year mod 100 and (year / 100) mod 4
	typedef struct packed {
		logic [6:0] r100;
		logic [1:0] cent4;
	} yres_t;

	// Result of the date check
	typedef struct packed {
		err_t  err;
		logic  same_month;
		yres_t ey_res;
	} chk_t;

	// Commands to the month walk unit
	typedef struct packed {
		logic clear;
		logic load;
		logic step;
	} walk_cmd_t;

	// Status of the month walk unit
	typedef struct packed {
		logic at_target;
		logic overrun;
	} walk_sts_t;

	// Split a year into its century residues with one constant multiply
	function automatic yres_t year_res(input logic [YEAR_W-1:0] y);
		logic [PROD_W-1:0] prod;
		logic [CENT_W-1:0] q;
		logic [YEAR_W-1:0] rem;
		yres_t             r;
		prod    = PROD_W'(y) * PROD_W'(RECIP_100);
		q       = prod[RECIP_SHIFT +: CENT_W];
		rem     = y - YEAR_W'(YEAR_W'(q) * YEARS_PER_CENTURY);
		r.r100  = rem[6:0];
		r.cent4 = q[1:0];
		return r;
	endfunction

	// Gregorian leap rule from year mod 4 and the century residues
	function automatic logic is_leap(input logic [1:0] y4, input yres_t r);
		return (y4 == 2'd0) && ((r.r100 != 7'd0) || (r.cent4 == 2'd0));
	endfunction

	// Length of a month; zero for a code that is no month
	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
		input logic leap);
		logic [DAY_W-1:0] len;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
			4'd2:                                       len = leap ? 5'd29 : 5'd28;
			default:                                    len = 5'd0;
		endcase
		return len;
	endfunction

endpackage

`default_nettype wire

// ----- sv/ddd_check.sv -----
// Date validity and order check, with the year residues that seed the month walk.
`default_nettype none

module ddd_check (
	input  wire logic [ddd_pkg::DAY_W-1:0]   earlier_day,
	input  wire logic [ddd_pkg::MONTH_W-1:0] earlier_month,
	input  wire logic [ddd_pkg::YEAR_W-1:0]  earlier_year,
	input  wire logic [ddd_pkg::DAY_W-1:0]   later_day,
	input  wire logic [ddd_pkg::MONTH_W-1:0] later_month,
	input  wire logic [ddd_pkg::YEAR_W-1:0]  later_year,
	output ddd_pkg::chk_t                    chk
);

	ddd_pkg::yres_t         e_res;
	ddd_pkg::yres_t         l_res;
	logic [ddd_pkg::DAY_W-1:0] e_len;
	logic [ddd_pkg::DAY_W-1:0] l_len;
	logic                   e_ok;
	logic                   l_ok;
	logic                   reversed;

	// Leap status of both years
	assign e_res = ddd_pkg::year_res(earlier_year);
	assign l_res = ddd_pkg::year_res(later_year);
	assign e_len = ddd_pkg::month_len(earlier_month,
		ddd_pkg::is_leap(earlier_year[1:0], e_res));
	assign l_len = ddd_pkg::month_len(later_month,
		ddd_pkg::is_leap(later_year[1:0], l_res));

	// Range checks; an invalid month has length zero and fails the day check
	always_comb begin
		e_ok = (earlier_year >= ddd_pkg::MIN_YEAR) && (earlier_year <= ddd_pkg::MAX_YEAR)
			&& (earlier_day != '0) && (earlier_day <= e_len);
		l_ok = (later_year >= ddd_pkg::MIN_YEAR) && (later_year <= ddd_pkg::MAX_YEAR)
			&& (later_day != '0) && (later_day <= l_len);
	end

	// Valid dates order the same way as year, month, day concatenated
	assign reversed = {later_year, later_month, later_day}
		< {earlier_year, earlier_month, earlier_day};

	always_comb begin
		if (!(e_ok && l_ok)) begin
			chk.err = ddd_pkg::ERR_INVALID;
		end else if (reversed) begin
			chk.err = ddd_pkg::ERR_ORDER;
		end else begin
			chk.err = ddd_pkg::ERR_NONE;
		end
		chk.same_month = (earlier_year == later_year) && (earlier_month == later_month);
		chk.ey_res     = e_res;
	end

endmodule

`default_nettype wire

// ----- sv/ddd_walk.sv -----
// Month walk unit: one shared adder accumulates one month length per step.
`default_nettype none

module ddd_walk (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire ddd_pkg::walk_cmd_t            cmd,
	input  wire ddd_pkg::yres_t                start_res,
	input  wire logic                          same_month,
	input  wire logic [ddd_pkg::DAY_W-1:0]     earlier_day,
	input  wire logic [ddd_pkg::MONTH_W-1:0]   earlier_month,
	input  wire logic [ddd_pkg::YEAR_W-1:0]    earlier_year,
	input  wire logic [ddd_pkg::DAY_W-1:0]     later_day,
	input  wire logic [ddd_pkg::MONTH_W-1:0]   later_month,
	input  wire logic [ddd_pkg::YEAR_W-1:0]    later_year,
	output ddd_pkg::walk_sts_t                 sts,
	output logic [ddd_pkg::COUNT_W-1:0]        count
);

	logic [ddd_pkg::MONTH_W-1:0] walk_month_q;
	logic [ddd_pkg::YEAR_W-1:0]  walk_year_q;
	ddd_pkg::yres_t              res_q;
	logic [ddd_pkg::COUNT_W-1:0] acc_q;
	logic                        first_q;

	logic [ddd_pkg::DAY_W-1:0]   len;
	logic [ddd_pkg::DAY_W-1:0]   addend;
	logic [ddd_pkg::COUNT_W:0]   sum;

	// Length of the current walk month, less the earlier day on the first step
	assign len    = ddd_pkg::month_len(walk_month_q, ddd_pkg::is_leap(walk_year_q[1:0], res_q));
	assign addend = first_q ? (len - earlier_day) : len;
	assign sum    = {1'b0, acc_q} + (ddd_pkg::COUNT_W + 1)'(addend);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_month_q <= ddd_pkg::JANUARY;
			walk_year_q  <= ddd_pkg::MIN_YEAR;
			res_q        <= '0;
			acc_q        <= '0;
			first_q      <= 1'b0;
		end else if (cmd.clear) begin
			acc_q   <= '0;
			first_q <= 1'b0;
		end else if (cmd.load) begin
			walk_month_q <= earlier_month;
			walk_year_q  <= earlier_year;
			res_q        <= start_res;
			first_q      <= 1'b1;
			// Both dates in one month: the day difference is the answer
			acc_q <= same_month ? ddd_pkg::COUNT_W'(later_day - earlier_day)
				: ddd_pkg::COUNT_W'(later_day);
		end else if (cmd.step) begin
			first_q <= 1'b0;
			// Partial sums never fall, so saturating each one is exact
			acc_q <= sum[ddd_pkg::COUNT_W] ? ddd_pkg::COUNT_MAX : sum[ddd_pkg::COUNT_W-1:0];
			if (walk_month_q == ddd_pkg::DECEMBER) begin
				walk_month_q <= ddd_pkg::JANUARY;
				walk_year_q  <= walk_year_q + 1'b1;
				if (res_q.r100 == ddd_pkg::LAST_IN_CENTURY) begin
					res_q.r100  <= '0;
					res_q.cent4 <= res_q.cent4 + 1'b1;
				end else begin
					res_q.r100 <= res_q.r100 + 1'b1;
				end
			end else begin
				walk_month_q <= walk_month_q + 1'b1;
			end
		end
	end

	assign sts.at_target = (walk_year_q == later_year) && (walk_month_q == later_month);
	assign sts.overrun   = {walk_year_q, walk_month_q} > {later_year, later_month};
	assign count         = acc_q;

endmodule

`default_nettype wire

// ----- sv/date_difference_in_days_unit.sv -----
// Top level of the date difference unit: handshakes, sequencer and result register.
//
// Usage:
//   Input channel in_valid/in_ready carries two dates (earlier and later day,
//   month, year). Output channel out_valid/out_ready returns day_count and
//   error_code (0 ok, 1 dates out of order, 2 invalid day, month or year).
//   A transaction completes when valid and ready are both high at a clock edge.
// Timing:
//   The dates are checked first, then the walk adds one month length per cycle
//   from the earlier month to the later month through a single adder; an
//   invalid or reversed pair skips the walk. One item is worked at a time;
//   in_ready is high only while idle, so a new item can be accepted in the
//   same cycle the previous result shows.
// Stalls:
//   The result sits in an output register; the unit takes the next item while
//   it waits. A finished walk holds until that register is free.
// Reset:
//   arst_n clears the sequencer and the output valid at once; no clearing
//   pass is needed and the unit is ready on the first cycle after reset.
`default_nettype none

module date_difference_in_days_unit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [ddd_pkg::DAY_W-1:0]   earlier_day,
	input  wire logic [ddd_pkg::MONTH_W-1:0] earlier_month,
	input  wire logic [ddd_pkg::YEAR_W-1:0]  earlier_year,
	input  wire logic [ddd_pkg::DAY_W-1:0]   later_day,
	input  wire logic [ddd_pkg::MONTH_W-1:0] later_month,
	input  wire logic [ddd_pkg::YEAR_W-1:0]  later_year,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [ddd_pkg::COUNT_W-1:0]      day_count,
	output logic [1:0]                       error_code
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_WALK,
		ST_DONE
	} state_t;

	state_t                      state_q;
	logic [ddd_pkg::DAY_W-1:0]   ed_q;
	logic [ddd_pkg::MONTH_W-1:0] em_q;
	logic [ddd_pkg::YEAR_W-1:0]  ey_q;
	logic [ddd_pkg::DAY_W-1:0]   ld_q;
	logic [ddd_pkg::MONTH_W-1:0] lm_q;
	logic [ddd_pkg::YEAR_W-1:0]  ly_q;
	ddd_pkg::err_t               err_q;
	logic                        out_valid_q;
	logic [ddd_pkg::COUNT_W-1:0] day_count_q;
	ddd_pkg::err_t               error_code_q;

	ddd_pkg::chk_t               chk;
	ddd_pkg::walk_cmd_t          cmd;
	ddd_pkg::walk_sts_t          sts;
	logic [ddd_pkg::COUNT_W-1:0] walk_count;
	logic                        in_fire;
	logic                        out_free;

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	ddd_check u_check (
		.earlier_day   (ed_q),
		.earlier_month (em_q),
		.earlier_year  (ey_q),
		.later_day     (ld_q),
		.later_month   (lm_q),
		.later_year    (ly_q),
		.chk           (chk)
	);

	ddd_walk u_walk (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.start_res     (chk.ey_res),
		.same_month    (chk.same_month),
		.earlier_day   (ed_q),
		.earlier_month (em_q),
		.earlier_year  (ey_q),
		.later_day     (ld_q),
		.later_month   (lm_q),
		.later_year    (ly_q),
		.sts           (sts),
		.count         (walk_count)
	);

	// Walk commands from the sequencer state
	always_comb begin
		cmd.clear = (state_q == ST_CHECK) && (chk.err != ddd_pkg::ERR_NONE);
		cmd.load  = (state_q == ST_CHECK) && (chk.err == ddd_pkg::ERR_NONE);
		cmd.step  = (state_q == ST_WALK) && !sts.at_target;
	end

	// Input capture
	always_ff @(posedge clk) begin
		if (in_fire) begin
			ed_q <= earlier_day;
			em_q <= earlier_month;
			ey_q <= earlier_year;
			ld_q <= later_day;
			lm_q <= later_month;
			ly_q <= later_year;
		end
	end

	// Sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			err_q        <= ddd_pkg::ERR_NONE;
			out_valid_q  <= 1'b0;
			day_count_q  <= '0;
			error_code_q <= ddd_pkg::ERR_NONE;
		end else begin
			// Drop valid on accept unless a new result loads in the same cycle
			if (out_valid_q && out_ready && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					err_q   <= chk.err;
					state_q <= (chk.err == ddd_pkg::ERR_NONE) ? ST_WALK : ST_DONE;
				end
				ST_WALK: begin
					if (sts.at_target) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						day_count_q  <= walk_count;
						error_code_q <= err_q;
						state_q      <= ST_IDLE;
					end else if (out_valid_q && out_ready) begin
						out_valid_q <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign day_count  = day_count_q;
	assign error_code = error_code_q;

	// An error result always carries a zero count
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (error_code != ddd_pkg::ERR_NONE) |-> day_count == '0)
		else $error("error result with nonzero day count");

	// The month walk never passes the later month
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> !sts.overrun)
		else $error("month walk passed the later date");

	// An accepted transaction is checked in the next cycle
	a_accept_check: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (state_q == ST_CHECK))
		else $error("accepted transaction not checked");

endmodule

`default_nettype wire
